>>> rtl/lfpr_pkg.sv
// lfpr_pkg: shared types and constants for the length-framed packet receiver
// used by lfpr_parser and length_framed_packet_receiver_top; no dependencies
package lfpr_pkg;

	// framing bytes
	localparam logic [7:0] START_BYTE = 8'h7E;
	localparam logic [7:0] END_BYTE   = 8'h7F;

	// default largest accepted payload length
	localparam int MAX_PAYLOAD_DEF = 1024;

	// result field widths
	localparam int KIND_W  = 2;
	localparam int DATA_W  = 8;
	localparam int INDEX_W = 10;
	localparam int FLEN_W  = 11;

	// receive phase
	typedef enum logic [2:0] {
		PH_HUNT    = 3'd0,
		PH_LEN     = 3'd1,
		PH_PAYLOAD = 3'd2,
		PH_TRAILER = 3'd3,
		PH_ERROR   = 3'd4
	} lfpr_phase_t;

	// result kind
	typedef enum logic [KIND_W-1:0] {
		KIND_PAYLOAD = 2'd0,
		KIND_ACCEPT  = 2'd1,
		KIND_CHKERR  = 2'd2
	} lfpr_kind_t;

	// one result item
	typedef struct packed {
		lfpr_kind_t          kind;
		logic [DATA_W-1:0]   data;
		logic [INDEX_W-1:0]  index;
		logic [FLEN_W-1:0]   flen;
	} lfpr_event_t;

endpackage

>>> rtl/lfpr_parser.sv
// lfpr_parser: frame state machine, length capture, checksum and result decode
// depends on lfpr_pkg
module lfpr_parser import lfpr_pkg::*; #(
	parameter int MAX_PAYLOAD = MAX_PAYLOAD_DEF
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        step,
	input  logic [7:0]  byte_in,
	output logic        ev_valid,
	output lfpr_event_t ev
);

	localparam int LEN_W = $clog2(MAX_PAYLOAD + 1);

	lfpr_phase_t      phase_q, phase_d;
	logic             low_seen_q, low_seen_d;
	logic [7:0]       low_byte_q, low_byte_d;
	logic [LEN_W-1:0] decl_q, decl_d;
	logic [LEN_W-1:0] count_q, count_d;
	logic [7:0]       sum_q, sum_d;
	logic [15:0]      len_full;

	assign len_full = {byte_in, low_byte_q};

	// state registers, updated once per processed item
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q    <= PH_HUNT;
			low_seen_q <= 1'b0;
			low_byte_q <= '0;
			decl_q     <= '0;
			count_q    <= '0;
			sum_q      <= '0;
		end else if (step) begin
			phase_q    <= phase_d;
			low_seen_q <= low_seen_d;
			low_byte_q <= low_byte_d;
			decl_q     <= decl_d;
			count_q    <= count_d;
			sum_q      <= sum_d;
		end
	end

	// next state and result for the byte at hand
	always_comb begin
		phase_d    = phase_q;
		low_seen_d = low_seen_q;
		low_byte_d = low_byte_q;
		decl_d     = decl_q;
		count_d    = count_q;
		sum_d      = sum_q;
		ev_valid   = 1'b0;
		ev.kind    = KIND_PAYLOAD;
		ev.data    = '0;
		ev.index   = '0;
		ev.flen    = FLEN_W'(decl_q);
		unique case (phase_q)
			PH_LEN: begin
				sum_d = sum_q + byte_in;
				if (!low_seen_q) begin
					low_byte_d = byte_in;
					low_seen_d = 1'b1;
				end else begin
					low_seen_d = 1'b0;
					count_d    = '0;
					if (len_full > 16'(MAX_PAYLOAD)) begin
						phase_d = PH_HUNT;
					end else begin
						decl_d  = len_full[LEN_W-1:0];
						phase_d = PH_PAYLOAD;
					end
				end
			end
			PH_PAYLOAD: begin
				if (count_q < decl_q) begin
					ev_valid = 1'b1;
					ev.kind  = KIND_PAYLOAD;
					ev.data  = byte_in;
					ev.index = INDEX_W'(count_q);
					sum_d    = sum_q + byte_in;
					count_d  = count_q + 1'b1;
				end else begin
					phase_d = (sum_q == byte_in) ? PH_TRAILER : PH_ERROR;
				end
			end
			PH_TRAILER: begin
				if (byte_in == END_BYTE) begin
					ev_valid = 1'b1;
					ev.kind  = KIND_ACCEPT;
					phase_d  = PH_HUNT;
				end
			end
			PH_ERROR: begin
				ev_valid = 1'b1;
				ev.kind  = KIND_CHKERR;
				phase_d  = PH_HUNT;
				decl_d   = '0;
				count_d  = '0;
			end
			default: begin
				// hunting, also covers unused phase codes
				phase_d = PH_HUNT;
				if (byte_in == START_BYTE) begin
					phase_d    = PH_LEN;
					low_seen_d = 1'b0;
					low_byte_d = '0;
					decl_d     = '0;
					count_d    = '0;
					sum_d      = '0;
				end
			end
		endcase
	end

`ifndef SYNTHESIS
	// payload count never runs past the declared length
	assert property (@(posedge clk) disable iff (!arst_n)
		phase_q == PH_PAYLOAD |-> count_q <= decl_q)
		else $error("payload count past declared length");

	// half-read length only exists in the length phase
	assert property (@(posedge clk) disable iff (!arst_n)
		low_seen_q |-> phase_q == PH_LEN)
		else $error("low length byte flag outside length phase");

	// a stored length is never above the limit
	assert property (@(posedge clk) disable iff (!arst_n)
		decl_q <= LEN_W'(MAX_PAYLOAD))
		else $error("declared length above the limit");
`endif

endmodule

>>> rtl/length_framed_packet_receiver_top.sv
// length_framed_packet_receiver_top: input register, parser and result register
// depends on lfpr_pkg and lfpr_parser
//
// Usage:
//   rx channel (rx_valid, rx_stall, rx_byte) carries one received byte per item.
//   evt channel (evt_valid, evt_stall, event_kind, data_byte, byte_index,
//   frame_length) carries zero or one result item per byte.
//   A byte is taken into an input register, run through the frame state
//   machine and checksum logic, and any result lands in an output register.
//   Throughput is one byte per cycle unless rx_stall holds the input; the
//   state update for a byte is combinational logic between the input and
//   result registers, so the next byte can follow immediately.
//   When evt_stall holds a waiting result, the input register still drains
//   bytes that give no result; rx_stall rises only when a byte is held that
//   needs the occupied result slot.
//   Reset (arst_n low) clears both registers' valid flags and returns the
//   parser to hunting for the start byte with length, count and sum at zero.
module length_framed_packet_receiver_top import lfpr_pkg::*; #(
	parameter int MAX_PAYLOAD = MAX_PAYLOAD_DEF
) (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               rx_valid,
	output logic               rx_stall,
	input  logic [DATA_W-1:0]  rx_byte,
	output logic               evt_valid,
	input  logic               evt_stall,
	output logic [KIND_W-1:0]  event_kind,
	output logic [DATA_W-1:0]  data_byte,
	output logic [INDEX_W-1:0] byte_index,
	output logic [FLEN_W-1:0]  frame_length
);

	logic              valid_s1;
	logic [DATA_W-1:0] byte_s1;
	logic              out_valid_q;
	lfpr_event_t       evt_q;
	logic              slot_free;
	logic              step;
	logic              ev_valid;
	lfpr_event_t       ev;

	// byte in s1 may proceed unless it makes a result with the slot still full
	assign slot_free = !out_valid_q || !evt_stall;
	assign step      = valid_s1 && (slot_free || !ev_valid);
	assign rx_stall  = valid_s1 && !step;

	// input register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (!rx_stall) begin
			valid_s1 <= rx_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (rx_valid && !rx_stall) begin
			byte_s1 <= rx_byte;
		end
	end

	lfpr_parser #(
		.MAX_PAYLOAD(MAX_PAYLOAD)
	) u_parser (
		.clk     (clk),
		.arst_n  (arst_n),
		.step    (step),
		.byte_in (byte_s1),
		.ev_valid(ev_valid),
		.ev      (ev)
	);

	// result register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (slot_free) begin
			out_valid_q <= step && ev_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (slot_free && step && ev_valid) begin
			evt_q <= ev;
		end
	end

	assign evt_valid    = out_valid_q;
	assign event_kind   = evt_q.kind;
	assign data_byte    = evt_q.data;
	assign byte_index   = evt_q.index;
	assign frame_length = evt_q.flen;

`ifndef SYNTHESIS
	// a stalled result item stays offered
	assert property (@(posedge clk) disable iff (!arst_n)
		evt_valid && evt_stall |=> evt_valid)
		else $error("result item dropped while stalled");

	// non-payload results carry zero data and index
	assert property (@(posedge clk) disable iff (!arst_n)
		evt_valid && event_kind != KIND_PAYLOAD |-> data_byte == '0 && byte_index == '0)
		else $error("non-payload item with data or index");

	// input only stalls behind a full, stalled result slot
	assert property (@(posedge clk) disable iff (!arst_n)
		rx_stall |-> valid_s1 && out_valid_q && evt_stall)
		else $error("input stall without a blocked result slot");
`endif

endmodule

>>> tb/length_framed_packet_receiver_top_tb.sv
`timescale 1ns / 100ps
// length_framed_packet_receiver_top_tb: self-checking bench for the frame receiver,
// own frame decoder as predictor, random idling and backpressure on both sides
// depends on lfpr_pkg and length_framed_packet_receiver_top
module length_framed_packet_receiver_top_tb;
	import lfpr_pkg::*;

	logic               clk       = 1'b0;
	logic               arst_n    = 1'b0;
	logic               rx_valid  = 1'b0;
	logic               rx_stall;
	logic [DATA_W-1:0]  rx_byte   = '0;
	logic               evt_valid;
	logic               evt_stall = 1'b0;
	logic [KIND_W-1:0]  event_kind;
	logic [DATA_W-1:0]  data_byte;
	logic [INDEX_W-1:0] byte_index;
	logic [FLEN_W-1:0]  frame_length;

	// idling rates in percent, long hold requests for the result side
	int unsigned send_idle_pct  = 0;
	int unsigned recv_stall_pct = 0;
	int unsigned hold_len       = 0;
	int unsigned hold_req_id    = 0;
	int unsigned hold_ack_id    = 0;
	int unsigned hold_left      = 0;

	// bookkeeping
	int unsigned bytes_sent   = 0;
	int unsigned fault_cnt    = 0;
	int unsigned seen_payload = 0;
	int unsigned seen_accept  = 0;
	int unsigned seen_chkerr  = 0;
	int unsigned frames_sent  = 0;

	// decoder state mirrored from the block
	lfpr_phase_t       fr_phase   = PH_HUNT;
	logic              fr_lo_seen = 1'b0;
	logic [7:0]        fr_lo_byte = '0;
	logic [FLEN_W-1:0] fr_length  = '0;
	logic [FLEN_W-1:0] fr_count   = '0;
	logic [7:0]        fr_sum     = '0;

	lfpr_event_t pending_events[$];

	length_framed_packet_receiver_top u_dut (
		.clk          (clk),
		.arst_n       (arst_n),
		.rx_valid     (rx_valid),
		.rx_stall     (rx_stall),
		.rx_byte      (rx_byte),
		.evt_valid    (evt_valid),
		.evt_stall    (evt_stall),
		.event_kind   (event_kind),
		.data_byte    (data_byte),
		.byte_index   (byte_index),
		.frame_length (frame_length)
	);

	// 2 ns clock
	always begin
		#1 clk = 1'b1;
		#1 clk = 1'b0;
	end

	// run limit, far above the slowest legal run
	initial begin
		#800000;
		$display("[length_framed_packet_receiver_top] ERROR");
		$finish;
	end

	// advance the frame decoder by one accepted byte, queue any result it causes
	task automatic frame_decode_byte(input logic [7:0] b);
		lfpr_event_t ev;
		logic [15:0] len;
		ev = '0;
		case (fr_phase)
			PH_LEN: begin
				fr_sum = fr_sum + b;
				if (!fr_lo_seen) begin
					fr_lo_byte = b;
					fr_lo_seen = 1'b1;
				end else begin
					fr_lo_seen = 1'b0;
					len = {b, fr_lo_byte};
					fr_count = '0;
					if (len > MAX_PAYLOAD_DEF) begin
						fr_phase = PH_HUNT;
					end else begin
						fr_length = len[FLEN_W-1:0];
						fr_phase = PH_PAYLOAD;
					end
				end
			end
			PH_PAYLOAD: begin
				if (fr_count < fr_length) begin
					ev.kind  = KIND_PAYLOAD;
					ev.data  = b;
					ev.index = fr_count[INDEX_W-1:0];
					ev.flen  = fr_length;
					pending_events.push_back(ev);
					fr_sum = fr_sum + b;
					fr_count = fr_count + 1'b1;
				end else begin
					fr_phase = (fr_sum == b) ? PH_TRAILER : PH_ERROR;
				end
			end
			PH_TRAILER: begin
				if (b == END_BYTE) begin
					ev.kind = KIND_ACCEPT;
					ev.flen = fr_length;
					pending_events.push_back(ev);
					fr_phase = PH_HUNT;
				end
			end
			PH_ERROR: begin
				// the byte after a bad checksum is swallowed whatever it is
				ev.kind = KIND_CHKERR;
				ev.flen = fr_length;
				pending_events.push_back(ev);
				fr_phase = PH_HUNT;
				fr_length = '0;
				fr_count = '0;
			end
			default: begin
				fr_phase = PH_HUNT;
				if (b == START_BYTE) begin
					fr_phase = PH_LEN;
					fr_lo_seen = 1'b0;
					fr_lo_byte = '0;
					fr_length = '0;
					fr_count = '0;
					fr_sum = '0;
				end
			end
		endcase
	endtask

	// offer one byte, with random idle cycles first; called and returns at a falling edge
	task automatic send_byte(input logic [7:0] b);
		while ($urandom_range(0, 99) < send_idle_pct) begin
			rx_valid <= 1'b0;
			@(negedge clk);
		end
		rx_valid <= 1'b1;
		rx_byte <= b;
		do
			@(posedge clk);
		while (rx_stall);
		frame_decode_byte(b);
		bytes_sent++;
		@(negedge clk);
	endtask

	// start byte, length, payload, checksum, then junk and trailer or the swallowed byte; ends after an over-limit length
	task automatic send_frame(input int unsigned plen, input bit corrupt,
			input int unsigned junk);
		logic [7:0] sum;
		logic [7:0] b;
		frames_sent++;
		send_byte(START_BYTE);
		send_byte(plen[7:0]);
		send_byte(plen[15:8]);
		if (plen > MAX_PAYLOAD_DEF)
			return;
		sum = plen[7:0] + plen[15:8];
		repeat (plen) begin
			b = 8'($urandom_range(0, 255));
			send_byte(b);
			sum = sum + b;
		end
		if (corrupt) begin
			send_byte(sum ^ 8'($urandom_range(1, 255)));
			send_byte(8'($urandom_range(0, 255)));
		end else begin
			send_byte(sum);
			repeat (junk) begin
				do
					b = 8'($urandom_range(0, 255));
				while (b == END_BYTE);
				send_byte(b);
			end
			send_byte(END_BYTE);
		end
	endtask

	// stop offering and wait for every queued result, plus the pipeline depth
	task automatic wait_drained();
		rx_valid <= 1'b0;
		while (pending_events.size() != 0)
			@(negedge clk);
		repeat (4) @(negedge clk);
	endtask

	// result side stall, with long holds on request
	always @(negedge clk) begin
		if (hold_req_id != hold_ack_id) begin
			hold_left = hold_len;
			hold_ack_id = hold_req_id;
		end
		if (hold_left > 0) begin
			hold_left--;
			evt_stall <= 1'b1;
		end else begin
			evt_stall <= ($urandom_range(0, 99) < recv_stall_pct);
		end
	end

	task automatic report_event_fault(input string what, input lfpr_event_t want);
		fault_cnt++;
		if (fault_cnt <= 10)
			$display({"%0t %s: expected kind=%0d data=%02h index=%0d len=%0d,",
				" got kind=%0d data=%02h index=%0d len=%0d"},
				$time, what, want.kind, want.data, want.index, want.flen,
				event_kind, data_byte, byte_index, frame_length);
	endtask

	// compare each accepted result with the oldest expectation
	always @(posedge clk) begin
		lfpr_event_t want;
		if (arst_n && evt_valid && !evt_stall) begin
			if (pending_events.size() == 0) begin
				report_event_fault("unexpected result", '0);
			end else begin
				want = pending_events.pop_front();
				if (event_kind !== want.kind || data_byte !== want.data ||
						byte_index !== want.index || frame_length !== want.flen)
					report_event_fault("result mismatch", want);
				case (want.kind)
					KIND_PAYLOAD: seen_payload++;
					KIND_ACCEPT:  seen_accept++;
					default:      seen_chkerr++;
				endcase
			end
		end
	end

	task automatic test_reset();
		arst_n = 1'b0;
		repeat (6) @(negedge clk);
		arst_n = 1'b1;
		repeat (2) @(negedge clk);
	endtask

	// hand-built frames covering each framing corner
	task automatic test_directed_framing();
		send_idle_pct = 0;
		recv_stall_pct = 0;
		// bytes ignored while hunting
		send_byte(8'h00);
		send_byte(8'hFF);
		send_byte(END_BYTE);
		// empty payload, good checksum
		send_byte(START_BYTE);
		send_byte(8'h00);
		send_byte(8'h00);
		send_byte(8'h00);
		send_byte(END_BYTE);
		// empty payload, bad checksum, start byte swallowed as the error byte
		send_byte(START_BYTE);
		send_byte(8'h00);
		send_byte(8'h00);
		send_byte(8'h05);
		send_byte(START_BYTE);
		// one over the limit and the largest length, both dropped
		send_byte(START_BYTE);
		send_byte(8'h01);
		send_byte(8'h04);
		send_byte(START_BYTE);
		send_byte(8'hFF);
		send_byte(8'hFF);
		// payload at both byte extremes, start byte ignored in the trailer
		send_byte(START_BYTE);
		send_byte(8'h02);
		send_byte(8'h00);
		send_byte(8'h00);
		send_byte(8'hFF);
		send_byte(8'h01);
		send_byte(START_BYTE);
		send_byte(END_BYTE);
		wait_drained();
	endtask

	// largest legal payload reaches the top index
	task automatic test_max_length();
		send_idle_pct = 5;
		recv_stall_pct = 5;
		send_frame(MAX_PAYLOAD_DEF, 1'b0, 1);
		wait_drained();
	endtask

	// long hold on the result side while bytes keep coming, then a full drain
	task automatic test_backpressure();
		send_idle_pct = 0;
		recv_stall_pct = 0;
		hold_len = 300;
		hold_req_id++;
		send_frame(60, 1'b0, 2);
		send_frame(3, 1'b1, 0);
		wait_drained();
	endtask

	// mostly well-formed frames with random content, some broken ones and noise
	task automatic test_random_traffic(input int unsigned sender_idle,
			input int unsigned receiver_idle, input int unsigned budget);
		int unsigned stop_at;
		int unsigned pick;
		int unsigned plen;
		send_idle_pct = sender_idle;
		recv_stall_pct = receiver_idle;
		stop_at = bytes_sent + budget;
		while (bytes_sent < stop_at) begin
			pick = $urandom_range(0, 99);
			if (pick < 12) begin
				repeat ($urandom_range(1, 3)) send_byte(8'($urandom_range(0, 255)));
			end else if (pick < 22) begin
				send_frame($urandom_range(MAX_PAYLOAD_DEF + 1, 65535), 1'b0, 0);
			end else begin
				plen = (pick < 30) ? $urandom_range(17, 200) : $urandom_range(0, 16);
				send_frame(plen, pick < 42, $urandom_range(0, 2));
			end
		end
		wait_drained();
	endtask

	initial begin
		test_reset();
		test_directed_framing();
		test_max_length();
		test_backpressure();
		test_random_traffic(13, 85, 200);
		test_random_traffic(85, 13, 200);
		test_random_traffic(0, 0, 200);
		repeat (20) @(negedge clk);
		$display("covered %0d bytes in %0d frames: %0d payload results, %0d accepted, %0d %s",
			bytes_sent, frames_sent, seen_payload, seen_accept, seen_chkerr,
			"checksum errors");
		$display("idling on both sides, a long result-side hold and a max-length frame; %0d faults",
			fault_cnt);
		if (fault_cnt == 0)
			$display("[length_framed_packet_receiver_top] OK");
		else
			$display("[length_framed_packet_receiver_top] ERROR");
		$finish;
	end

endmodule
